// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the 1-Wire ROM search master.
// The clock is clk and the asynchronous active-low reset is arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_AT(lbl, !(cond), msg)

`endif

// ===== sv/owrs_pkg.sv =====
// Shared types and constants of the 1-Wire ROM search master.
// No dependencies; the interfaces and the master import this package.
`timescale 1ns / 1ps
package owrs_pkg;

	localparam int ROM_W         = 64;
	localparam int ADDR_BITS_DEF = 64;

	localparam logic OP_START = 1'b0;
	localparam logic OP_ECHO  = 1'b1;

	localparam logic [7:0] PROBE_RESET = 8'hf0;
	localparam logic [7:0] PROBE_ONE   = 8'hff;
	localparam logic [7:0] PROBE_ZERO  = 8'h00;
	localparam logic [7:0] SEARCH_CMD  = 8'hf0;
	localparam logic [7:0] HIGH_NIBBLE = 8'hf0;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_NONE     = 2'd1,
		ST_VANISHED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]       probe_byte;
		logic             slow_baud;
		logic             done_res;
		status_t          search_status;
		logic [ROM_W-1:0] found_address;
	} result_t;

endpackage

// ===== sv/owrs_req_if.sv =====
// Request channel of the 1-Wire ROM search master: start or echo requests.
// Depends on owrs_pkg for the address width.
`timescale 1ns / 1ps
interface owrs_req_if;
	import owrs_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [ROM_W-1:0] start_address;
	logic [7:0]       echo_byte;

	modport source (output valid, opcode, start_address, echo_byte, input ready);
	modport sink   (input valid, opcode, start_address, echo_byte, output ready);
endinterface

// ===== sv/owrs_res_if.sv =====
// Result channel of the 1-Wire ROM search master: next probe or final status.
// Depends on owrs_pkg for the address width.
`timescale 1ns / 1ps
interface owrs_res_if;
	import owrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       probe_byte;
	logic             slow_baud;
	logic             done_res;
	logic [1:0]       search_status;
	logic [ROM_W-1:0] found_address;

	modport source (output valid, probe_byte, slow_baud, done_res, search_status,
		found_address, input ready);
	modport sink   (input valid, probe_byte, slow_baud, done_res, search_status,
		found_address, output ready);
endinterface

// ===== sv/onewire_rom_search_master.sv =====
// Channel  Role   Payload
// req      sink   opcode, start_address, echo_byte
// res      source probe_byte, slow_baud, done_res, search_status, found_address
//
// Each request is decided in the cycle it is accepted; its result is in the output
// register on the next cycle, so one request per cycle is sustained while res.ready is high.
// The slot decision is a single pass of logic between the search state and the
// result register. A waiting result stalls the request side only when res.ready is low.
// An echo while idle gives no result. Reset clears the phase, the branch flag and the result valid.
// Depends on owrs_pkg, owrs_req_if, owrs_res_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module onewire_rom_search_master #(
	parameter int ADDR_BITS = owrs_pkg::ADDR_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	owrs_req_if.sink  req,
	owrs_res_if.source res
);
	import owrs_pkg::*;

	localparam int             PW       = $clog2(ADDR_BITS);
	localparam logic [PW-1:0]  LAST_BIT = PW'(ADDR_BITS - 1);

	typedef enum logic [10:0] {
		PH_IDLE  = 11'b000_0000_0001,
		PH_RST1  = 11'b000_0000_0010,
		PH_CMD1  = 11'b000_0000_0100,
		PH_RD0_1 = 11'b000_0000_1000,
		PH_RD1_1 = 11'b000_0001_0000,
		PH_WR_1  = 11'b000_0010_0000,
		PH_RST2  = 11'b000_0100_0000,
		PH_CMD2  = 11'b000_1000_0000,
		PH_RD0_2 = 11'b001_0000_0000,
		PH_RD1_2 = 11'b010_0000_0000,
		PH_WR_2  = 11'b100_0000_0000
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [PW-1:0]        bit_q, bit_n;
	logic [2:0]           slot_q, slot_n;
	logic [ADDR_BITS-1:0] rom_q, rom_n;
	logic                 branch_valid_q, branch_valid_n;
	logic [PW-1:0]        branch_q, branch_n;
	logic                 zero_seen_q, zero_seen_n;
	logic                 res_valid_q;
	result_t              res_q, res_n;

	logic                 req_fire;
	logic                 emit;
	logic                 fin;
	status_t              fin_status;
	logic                 end_pass;
	logic                 line_low;
	logic                 prev_bit;
	logic [7:0]           probe;
	logic                 slow;

	logic                 start_fire;
	logic                 done_fire;
	logic                 reset_probe_out;
	logic                 in_pass_two;

	assign req.ready = !res_valid_q || res.ready;
	assign req_fire  = req.valid && req.ready;

	// In a read slot, any echo other than all ones means a device pulled the line low.
	assign line_low = req.echo_byte != PROBE_ONE;
	assign prev_bit = rom_q[bit_q];

	always_comb begin
		phase_n        = phase_q;
		bit_n          = bit_q;
		slot_n         = slot_q;
		rom_n          = rom_q;
		branch_valid_n = branch_valid_q;
		branch_n       = branch_q;
		zero_seen_n    = zero_seen_q;
		emit           = 1'b1;
		fin            = 1'b0;
		fin_status     = ST_FOUND;
		end_pass       = 1'b0;
		probe          = PROBE_ONE;
		slow           = 1'b0;

		if (req.opcode == OP_START) begin
			rom_n          = req.start_address[ADDR_BITS-1:0];
			branch_valid_n = 1'b0;
			bit_n          = '0;
			slot_n         = '0;
			zero_seen_n    = 1'b0;
			phase_n        = PH_RST1;
			probe          = PROBE_RESET;
			slow           = 1'b1;
		end else begin
			case (phase_q)
				PH_RST1, PH_RST2: begin
					if ((req.echo_byte & HIGH_NIBBLE) == HIGH_NIBBLE) begin
						fin        = 1'b1;
						fin_status = ST_NONE;
					end else begin
						phase_n = (phase_q == PH_RST1) ? PH_CMD1 : PH_CMD2;
						slot_n  = '0;
						probe   = SEARCH_CMD[0] ? PROBE_ONE : PROBE_ZERO;
					end
				end
				PH_CMD1, PH_CMD2: begin
					if (slot_q != 3'd7) begin
						slot_n = slot_q + 3'd1;
						probe  = SEARCH_CMD[slot_n] ? PROBE_ONE : PROBE_ZERO;
					end else begin
						slot_n  = '0;
						bit_n   = '0;
						phase_n = (phase_q == PH_CMD1) ? PH_RD0_1 : PH_RD0_2;
					end
				end
				PH_RD0_1, PH_RD0_2: begin
					zero_seen_n = line_low;
					phase_n     = (phase_q == PH_RD0_1) ? PH_RD1_1 : PH_RD1_2;
				end
				PH_RD1_1: begin
					// A zero bit with devices on the one side is a later branch candidate.
					if (!prev_bit) begin
						if (line_low) begin
							branch_valid_n = 1'b1;
							branch_n       = bit_q;
						end
						if (!zero_seen_q) begin
							end_pass = 1'b1;
						end
					end else if (!line_low) begin
						end_pass = 1'b1;
					end
					if (!end_pass) begin
						phase_n = PH_WR_1;
						probe   = prev_bit ? PROBE_ONE : PROBE_ZERO;
					end
				end
				PH_WR_1: begin
					if (bit_q == LAST_BIT) begin
						end_pass = 1'b1;
					end else begin
						bit_n   = bit_q + PW'(1);
						phase_n = PH_RD0_1;
					end
				end
				PH_RD1_2: begin
					if (bit_q < branch_q) begin
						probe = prev_bit ? PROBE_ONE : PROBE_ZERO;
					end else if (bit_q == branch_q) begin
						if (!line_low) begin
							fin        = 1'b1;
							fin_status = ST_VANISHED;
						end else begin
							rom_n[bit_q] = 1'b1;
						end
					end else if (zero_seen_q) begin
						rom_n[bit_q] = 1'b0;
						probe        = PROBE_ZERO;
					end else if (line_low) begin
						rom_n[bit_q] = 1'b1;
					end else begin
						fin        = 1'b1;
						fin_status = ST_VANISHED;
					end
					if (!fin) begin
						phase_n = PH_WR_2;
					end
				end
				PH_WR_2: begin
					if (bit_q == LAST_BIT) begin
						fin        = 1'b1;
						fin_status = ST_FOUND;
					end else begin
						bit_n   = bit_q + PW'(1);
						phase_n = PH_RD0_2;
					end
				end
				default: begin
					phase_n = PH_IDLE;
					emit    = 1'b0;
				end
			endcase
		end

		if (end_pass) begin
			if (!branch_valid_n) begin
				fin        = 1'b1;
				fin_status = ST_NONE;
			end else begin
				phase_n = PH_RST2;
				probe   = PROBE_RESET;
				slow    = 1'b1;
			end
		end

		if (fin) begin
			phase_n = PH_IDLE;
			probe   = PROBE_ZERO;
			slow    = 1'b0;
		end

		res_n.probe_byte    = probe;
		res_n.slow_baud     = slow;
		res_n.done_res      = fin;
		res_n.search_status = fin ? fin_status : ST_FOUND;
		res_n.found_address = ROM_W'(rom_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			branch_valid_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (req_fire) begin
				phase_q        <= phase_n;
				branch_valid_q <= branch_valid_n;
			end
			if (req_fire && emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			bit_q       <= bit_n;
			slot_q      <= slot_n;
			rom_q       <= rom_n;
			branch_q    <= branch_n;
			zero_seen_q <= zero_seen_n;
		end
		if (req_fire && emit) begin
			res_q <= res_n;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.probe_byte    = res_q.probe_byte;
	assign res.slow_baud     = res_q.slow_baud;
	assign res.done_res      = res_q.done_res;
	assign res.search_status = res_q.search_status;
	assign res.found_address = res_q.found_address;

	assign start_fire      = req_fire && req.opcode == OP_START;
	assign done_fire       = req_fire && emit && res_n.done_res;
	assign reset_probe_out = res.valid && res.probe_byte == PROBE_RESET && res.slow_baud;
	assign in_pass_two     = phase_q == PH_RST2 || phase_q == PH_CMD2 || phase_q == PH_RD0_2 ||
		phase_q == PH_RD1_2 || phase_q == PH_WR_2;

	`ASSERT_AT(a_start_gives_reset, start_fire |=> reset_probe_out, "start gave no reset probe")
	`ASSERT_AT(a_done_goes_idle, done_fire |=> phase_q == PH_IDLE, "finished search left phase busy")
	`ASSERT_NEVER(a_pass_two_branch, in_pass_two && !branch_valid_q, "second pass without a branch")

endmodule
